// ===== src/box_blur_5x5_then_grayscale_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BOX_BLUR_5X5_THEN_GRAYSCALE_TOP_ASSERT_SVH
`define BOX_BLUR_5X5_THEN_GRAYSCALE_TOP_ASSERT_SVH

// Check that a condition implies another one on the next clock, outside reset.
`define BBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition holds at every clock, outside reset.
`define BBG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a next-cycle implication that also spans reset.
`define BBG_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bbg_pkg.sv =====
package bbg_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int WIN_ROWS  = 5;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW_W      = COL_W + 1;
  localparam int MEM_DEPTH = WIN_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LEAD_W    = $clog2(2 * MAX_WIDTH + 3);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 16;
  localparam int PIX_W     = 24;
  localparam int SUM_W     = 13;
  localparam int CNT_W     = 5;
  localparam int DIV_CNT_W = 4;
  localparam int QSUM_W    = 10;
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // item operations
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic [HGT_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic [2:0]       rmod;
    logic             last;
    logic [EW_W-1:0]  w;
    logic [HGT_W-1:0] h;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // reduce a value below 15 modulo the window row count
  function automatic logic [2:0] mod5(input logic [3:0] x);
    logic [3:0] y;
    y = x;
    if (y >= 4'd10) begin
      y = y - 4'd10;
    end else if (y >= 4'd5) begin
      y = y - 4'd5;
    end
    return y[2:0];
  endfunction

  // line store address of (row slot, column)
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [2:0] slot,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

// ===== src/box_blur_5x5_then_grayscale_top.sv =====
// 5x5 box blur followed by gray conversion over a raster-order RGB frame.
// Input channel: in_valid/in_ready with in_operation (push a pixel or drain
// one pending result) and in_red/in_green/in_blue. Result channel:
// out_valid/out_ready with out_gray and out_last_of_frame.
// A result appears once a pixel 2*width+2 places later is pushed; after the
// last pixel of the frame, each drain beat releases one more result. Pushes
// past the end of the frame and early drains are dropped.
// From the accepting beat to out_valid the back end pops the job queue, makes
// 25 line store reads for the window over the single read port, takes a flush
// step, runs the restoring divider on all three channels and loads the output
// register; it works on one result at a time and pops the next job only from
// idle. A push is taken only while the job queue is empty and the back end is
// not reading the window, so a push that yields a result holds off the next
// push until the scan and flush are over; drains queue up in a two-entry job
// queue. Registers over the APB port: frame_width at 0x0, frame_height at 0x4.
// Writing either restarts the frame. Reset restores 640 x 480 and empties the
// queue and output register. When the receiver stalls, the output register
// holds its beat and the job queue fills, then in_ready drops.
module box_blur_5x5_then_grayscale_top
  import bbg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_gray,
  output logic               out_last_of_frame
);

  q_stat_t q_stat;
  logic    bk_busy, q_push, q_pop;
  job_t    q_job, head_job;
  mem_wr_t mem_wr;

  assign pready = 1'b1;

  bbg_front u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid, .in_ready, .in_operation, .in_red, .in_green, .in_blue,
    .q_stat, .bk_busy, .q_push, .q_job, .mem_wr
  );

  bbg_jobq u_jobq (
    .clk, .rst_n, .push(q_push), .push_job(q_job), .pop(q_pop),
    .head_job, .stat(q_stat)
  );

  bbg_back u_back (
    .clk, .rst_n, .mem_wr, .q_stat, .head_job, .q_pop, .busy(bk_busy),
    .out_valid, .out_ready, .out_gray, .out_last_of_frame
  );

endmodule

// ===== src/bbg_jobq.sv =====
module bbg_jobq
  import bbg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t stat
);

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head_job   = slot_r[rptr_r];

  // advance pointers and fill count
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== src/bbg_front.sv =====
module bbg_front
  import bbg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  q_stat_t            q_stat,
  input  logic               bk_busy,
  output logic               q_push,
  output job_t               q_job,
  output mem_wr_t            mem_wr
);

  logic [WID_W-1:0]  fw_r, fw_nxt;
  logic [HGT_W-1:0]  fh_r, fh_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [HGT_W-1:0]  in_row_r, in_row_nxt;
  logic [2:0]        in_rmod_r, in_rmod_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [HGT_W-1:0]  out_row_r, out_row_nxt;
  logic [2:0]        out_rmod_r, out_rmod_nxt;
  logic [LEAD_W-1:0] lead_r, lead_nxt;

  logic [EW_W-1:0]   ew;
  logic [HGT_W-1:0]  eh;
  logic [LEAD_W-1:0] lead_lim;
  logic              complete, acc, do_push, do_drain, emit, out_last, cfg_wr;
  logic              in_col_end, out_col_end;

  // effective frame size
  always_comb begin
    if (fw_r == '0) begin
      ew = EW_W'(1);
    end else if (fw_r > WID_W'(MAX_WIDTH)) begin
      ew = EW_W'(MAX_WIDTH);
    end else begin
      ew = EW_W'(fw_r);
    end
    eh = (fh_r == '0) ? HGT_W'(1) : fh_r;
  end

  assign lead_lim    = LEAD_W'({ew, 1'b0}) + LEAD_W'(2);
  assign complete    = (in_row_r >= eh);
  assign in_ready    = !q_stat.full &&
                       ((in_operation == OP_DRAIN) || (q_stat.empty && !bk_busy));
  assign acc         = in_valid && in_ready;
  assign do_push     = acc && (in_operation == OP_PUSH) && !complete;
  assign do_drain    = acc && (in_operation == OP_DRAIN) && complete;
  assign emit        = do_drain || (do_push && (lead_r == lead_lim));
  assign in_col_end  = ({1'b0, in_col_r} + EW_W'(1)) == ew;
  assign out_col_end = ({1'b0, out_col_r} + EW_W'(1)) == ew;
  assign out_last    = ((HGT_W + 1)'(out_row_r) + 17'd1 == {1'b0, eh}) && out_col_end;
  assign cfg_wr      = psel && penable && pwrite;

  // write the pushed pixel into its row slot
  assign mem_wr.en   = do_push;
  assign mem_wr.addr = mem_addr(in_rmod_r, in_col_r);
  assign mem_wr.data = {in_red, in_green, in_blue};

  // hand the result position to the back end
  assign q_push     = emit;
  assign q_job.orow = out_row_r;
  assign q_job.ocol = out_col_r;
  assign q_job.rmod = out_rmod_r;
  assign q_job.last = out_last;
  assign q_job.w    = ew;
  assign q_job.h    = eh;

  // read back registers
  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = DATA_W'(fw_r);
      REG_HEIGHT: prdata = DATA_W'(fh_r);
      default:    prdata = '0;
    endcase
  end

  // advance input and output positions
  always_comb begin
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_rmod_nxt  = in_rmod_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_rmod_nxt = out_rmod_r;
    lead_nxt     = lead_r;
    if (do_push) begin
      if (in_col_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + HGT_W'(1);
        in_rmod_nxt = (in_rmod_r == 3'd4) ? 3'd0 : in_rmod_r + 3'd1;
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (lead_r != lead_lim) begin
        lead_nxt = lead_r + LEAD_W'(1);
      end
    end
    if (emit) begin
      if (out_last) begin
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        in_rmod_nxt  = '0;
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_rmod_nxt = '0;
        lead_nxt     = '0;
      end else if (out_col_end) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + HGT_W'(1);
        out_rmod_nxt = (out_rmod_r == 3'd4) ? 3'd0 : out_rmod_r + 3'd1;
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
    // a register write restarts the frame
    if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        fw_nxt = pwdata[WID_W-1:0];
      end else begin
        fh_nxt = pwdata[HGT_W-1:0];
      end
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_rmod_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_rmod_nxt = '0;
      lead_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= WIDTH_RESET;
      fh_r       <= HEIGHT_RESET;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_rmod_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_rmod_r <= '0;
      lead_r     <= '0;
    end else begin
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_rmod_r  <= in_rmod_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_rmod_r <= out_rmod_nxt;
      lead_r     <= lead_nxt;
    end
  end

endmodule

// ===== src/bbg_back.sv =====
module bbg_back
  import bbg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_wr_t    mem_wr,
  input  q_stat_t    q_stat,
  input  job_t       head_job,
  output logic       q_pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_gray,
  output logic       out_last_of_frame
);

  logic [PIX_W-1:0]     mem [MEM_DEPTH];

  bk_state_t            state_r, state_nxt;
  job_t                 job_r;
  logic [2:0]           dr_r, dc_r;
  logic                 rvld_r;
  logic [PIX_W-1:0]     rdata_r;
  logic [SUM_W-1:0]     sr_r, sg_r, sb_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     rem_r [3];
  logic [SUM_W-1:0]     quo_r [3];
  logic [DIV_CNT_W-1:0] div_r;
  logic                 oval_r;
  logic [7:0]           gray_r;
  logic                 last_r;

  logic signed [HGT_W+1:0] rr;
  logic signed [EW_W+1:0]  cc;
  logic                    inb, scan_end, out_free;
  logic [2:0]              slot;
  logic [CNT_W-1:0]        divisor;
  logic [QSUM_W-1:0]       qsum;
  logic [QSUM_W+RECIP3_SH-1:0] prod;

  // window position of the current scan step
  assign rr   = $signed({2'b00, job_r.orow}) + $signed({{(HGT_W-1){1'b0}}, dr_r})
                - $signed((HGT_W + 2)'(2));
  assign cc   = $signed({2'b00, 1'b0, job_r.ocol}) + $signed({{(EW_W-1){1'b0}}, dc_r})
                - $signed((EW_W + 2)'(2));
  assign inb  = (rr >= 0) && (rr < $signed({2'b00, job_r.h})) &&
                (cc >= 0) && (cc < $signed({2'b00, job_r.w}));
  assign slot = mod5({1'b0, job_r.rmod} + {1'b0, dr_r} + 4'd3);
  assign scan_end = (dr_r == 3'd4) && (dc_r == 3'd4);
  assign out_free = !oval_r || out_ready;
  assign divisor  = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
  assign qsum     = QSUM_W'(quo_r[0]) + QSUM_W'(quo_r[1]) + QSUM_W'(quo_r[2]);
  assign prod     = (QSUM_W + RECIP3_SH)'(qsum) * (QSUM_W + RECIP3_SH)'(RECIP3);

  assign busy  = (state_r == BK_SCAN) || (state_r == BK_FLUSH);
  assign q_pop = (state_r == BK_IDLE) && !q_stat.empty;

  assign out_valid         = oval_r;
  assign out_gray          = gray_r;
  assign out_last_of_frame = last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = BK_SCAN;
      BK_SCAN:  if (scan_end) state_nxt = BK_FLUSH;
      BK_FLUSH: state_nxt = BK_DIV;
      BK_DIV:   if (div_r == DIV_CNT_W'(SUM_W - 1)) state_nxt = BK_DONE;
      BK_DONE:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    rdata_r <= mem[mem_addr(slot, cc[COL_W-1:0])];
  end

  // read-valid flag tracks the scan step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= (state_r == BK_SCAN) && inb;
    end
  end

  // scan, accumulate and divide
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= head_job;
      dr_r  <= '0;
      dc_r  <= '0;
      sr_r  <= '0;
      sg_r  <= '0;
      sb_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (state_r == BK_SCAN) begin
        if (dc_r == 3'd4) begin
          dc_r <= '0;
          dr_r <= dr_r + 3'd1;
        end else begin
          dc_r <= dc_r + 3'd1;
        end
      end
      if (rvld_r) begin
        sr_r  <= sr_r + SUM_W'(rdata_r[23:16]);
        sg_r  <= sg_r + SUM_W'(rdata_r[15:8]);
        sb_r  <= sb_r + SUM_W'(rdata_r[7:0]);
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
    if (state_r == BK_FLUSH) begin
      div_r <= '0;
    end else if (state_r == BK_DIV) begin
      div_r <= div_r + DIV_CNT_W'(1);
    end
  end

  // restoring divider, one quotient bit per cycle on all three channels
  always_ff @(posedge clk) begin
    logic [CNT_W:0] t;
    if (state_r == BK_FLUSH) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= '0;
      end
      quo_r[0] <= rvld_r ? sr_r + SUM_W'(rdata_r[23:16]) : sr_r;
      quo_r[1] <= rvld_r ? sg_r + SUM_W'(rdata_r[15:8]) : sg_r;
      quo_r[2] <= rvld_r ? sb_r + SUM_W'(rdata_r[7:0]) : sb_r;
    end else if (state_r == BK_DIV) begin
      for (int k = 0; k < 3; k++) begin
        t = {rem_r[k], quo_r[k][SUM_W-1]};
        if (t >= {1'b0, divisor}) begin
          rem_r[k] <= CNT_W'(t - {1'b0, divisor});
          quo_r[k] <= {quo_r[k][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= t[CNT_W-1:0];
          quo_r[k] <= {quo_r[k][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if ((state_r == BK_DONE) && out_free) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == BK_DONE) && out_free) begin
      gray_r <= prod[RECIP3_SH +: 8];
      last_r <= job_r.last;
    end
  end

endmodule

// ===== src/bbg_chk.sv =====
`include "box_blur_5x5_then_grayscale_top_assert.svh"

module bbg_chk
  import bbg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       pready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_gray,
  input logic       out_last_of_frame
);

  logic stall;

  assign stall = out_valid && !out_ready;

  // stalled result beat stays put
  `BBG_ASSERT_NEXT(a_out_hold, stall, out_valid, "result beat dropped while stalled")
  `BBG_ASSERT_NEXT(a_gray_stable, stall, $stable(out_gray), "gray changed while stalled")
  `BBG_ASSERT_NEXT(a_last_stable, stall, $stable(out_last_of_frame), "last flag moved in stall")
  // register port never waits
  `BBG_ASSERT_ALWAYS(a_pready, pready, "pready low")
  // reset empties the output register
  `BBG_ASSERT_RESET(a_rst_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind box_blur_5x5_then_grayscale_top bbg_chk u_chk (.*);
